### design/xfec_pkg.sv
// ----------------------------------------------------------------------------
// xfec_pkg
// Shared types and constants for the XOR parity FEC packetizer.
// ----------------------------------------------------------------------------
package xfec_pkg;

  localparam int SEQ_W   = 32;
  localparam int MS_W    = 32;
  localparam int POS_W   = 5;
  localparam int WORD_W  = 64;
  localparam int COUNT_W = 5;
  localparam int BASE_W  = 16;
  localparam int LOG2_W  = 3;
  localparam int DUP_W   = 5;

  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;

  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 160;

  localparam logic [CFG_IDX_W-1:0] REG_GROUP_LOG2 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUP_FRAMES = 1'd1;

  localparam logic [LOG2_W-1:0] GROUP_LOG2_RST = 3'd2;
  localparam logic [LOG2_W-1:0] GROUP_LOG2_MAX = 3'd4;
  localparam logic [DUP_W-1:0]  DUP_FRAMES_RST = 5'd2;

  localparam logic PKT_DATA   = 1'b0;
  localparam logic PKT_PARITY = 1'b1;

  typedef struct packed {
    logic accept;
    logic emit_data;
    logic tail_start;
    logic tail_read;
    logic tail_emit;
    logic tail_par;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic in_range;
    logic is_last;
    logic parity_due;
    logic replay_due;
    logic cnt_last;
  } status_t;

endpackage

### design/xfec_ctrl.sv
// ----------------------------------------------------------------------------
// xfec_ctrl
// Sequencer: takes one input word, emits its data word, then walks the
// parity or replay packet when the frame ends and one is due.
// ----------------------------------------------------------------------------
module xfec_ctrl
  import xfec_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DATA,
    S_TRD,
    S_TEMIT
  } state_t;

  state_t state;
  logic   tail_par;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.tail_par = tail_par;
    case (state)
      S_IDLE: begin
        cmd.accept = s_tvalid;
      end
      S_DATA: begin
        cmd.emit_data  = status.out_free;
        cmd.tail_start = status.out_free;
      end
      S_TRD: begin
        cmd.tail_read = 1'b1;
      end
      S_TEMIT: begin
        cmd.tail_emit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      tail_par <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) state <= S_DATA;
        end
        S_DATA: begin
          if (status.out_free) begin
            if (status.in_range && status.is_last &&
                (status.parity_due || status.replay_due)) begin
              tail_par <= status.parity_due;
              state    <= S_TRD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_TRD: begin
          state <= S_TEMIT;
        end
        S_TEMIT: begin
          if (status.out_free) begin
            state <= status.cnt_last ? S_IDLE : S_TRD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### design/xfec_datapath.sv
// ----------------------------------------------------------------------------
// xfec_datapath
// Input hold registers, parity and frame stores, header math, config
// registers and the output register.
// ----------------------------------------------------------------------------
module xfec_datapath
  import xfec_pkg::*;
#(
  parameter int WORDS_PER_FRAME = 20
)
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tuser,
  output logic                   m_tlast,
  input  cmd_t                   cmd,
  output status_t                status
);

  localparam int AW = (WORDS_PER_FRAME > 1) ? $clog2(WORDS_PER_FRAME) : 1;
  localparam int PW = (AW > POS_W) ? AW : POS_W;

  logic [WORD_W-1:0] parity_mem [WORDS_PER_FRAME];
  logic [WORD_W-1:0] frame_mem  [WORDS_PER_FRAME];
  logic [WORDS_PER_FRAME-1:0] par_valid;

  logic [SEQ_W-1:0]  h_seq;
  logic [MS_W-1:0]   h_now;
  logic [POS_W-1:0]  h_pos;
  logic [WORD_W-1:0] h_word;
  logic [MS_W-1:0]   frame_time;

  logic [LOG2_W-1:0] group_log2;
  logic [DUP_W-1:0]  dup_frames;

  logic [AW-1:0]     cnt;
  logic [WORD_W-1:0] rd_par;
  logic              rd_pv;
  logic [WORD_W-1:0] rd_frm;

  logic [POS_W-1:0]  in_pos;
  logic [PW-1:0]     in_pos_w;
  logic              in_ok;
  logic [AW-1:0]     rd_addr;
  logic [PW-1:0]     h_pos_w;
  logic [AW-1:0]     h_addr;

  logic [LOG2_W-1:0] eff_log2;
  logic [COUNT_W-1:0] count;
  logic [SEQ_W-1:0]  mask;
  logic [SEQ_W-1:0]  in_group;
  logic [BASE_W-1:0] base;
  logic [WORD_W-1:0] par_word;
  logic              out_free;

  assign in_pos   = s_tdata[68:64];
  assign in_pos_w = PW'(in_pos);
  assign in_ok    = 32'(in_pos) < 32'(WORDS_PER_FRAME);
  assign rd_addr  = cmd.tail_read ? cnt : (in_ok ? in_pos_w[AW-1:0] : '0);

  assign h_pos_w  = PW'(h_pos);
  assign h_addr   = h_pos_w[AW-1:0];

  assign eff_log2 = (group_log2 > GROUP_LOG2_MAX) ? GROUP_LOG2_MAX : group_log2;
  assign count    = COUNT_W'(1) << eff_log2;
  assign mask     = SEQ_W'(count) - SEQ_W'(1);
  assign in_group = h_seq & mask;
  assign base     = BASE_W'(h_seq & ~mask);
  assign par_word = rd_pv ? rd_par : '0;
  assign out_free = !m_tvalid || m_tready;

  assign status.out_free   = out_free;
  assign status.in_range   = 32'(h_pos) < 32'(WORDS_PER_FRAME);
  assign status.is_last    = 32'(h_pos) == 32'(WORDS_PER_FRAME - 1);
  assign status.parity_due = (in_group == mask);
  assign status.replay_due = in_group < SEQ_W'(dup_frames);
  assign status.cnt_last   = (cnt == AW'(WORDS_PER_FRAME - 1));

  always_ff @(posedge clk) begin
    if (cmd.accept || cmd.tail_read) begin
      rd_par <= parity_mem[rd_addr];
      rd_pv  <= par_valid[rd_addr];
      rd_frm <= frame_mem[rd_addr];
    end
    if (cmd.emit_data && status.in_range) begin
      parity_mem[h_addr] <= par_word ^ h_word;
      frame_mem[h_addr]  <= h_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      h_seq  <= s_tdata[31:0];
      h_now  <= s_tdata[63:32];
      h_pos  <= in_pos;
      h_word <= s_tdata[132:69];
    end
    if (cmd.tail_start) begin
      cnt <= '0;
    end else if (cmd.tail_emit && !status.cnt_last) begin
      cnt <= cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      par_valid  <= '0;
      frame_time <= '0;
      group_log2 <= GROUP_LOG2_RST;
      dup_frames <= DUP_FRAMES_RST;
    end else begin
      if (cfg_we && cfg_index == REG_GROUP_LOG2) group_log2 <= cfg_data[LOG2_W-1:0];
      if (cfg_we && cfg_index == REG_DUP_FRAMES) dup_frames <= cfg_data[DUP_W-1:0];
      if (cmd.emit_data && status.in_range) begin
        par_valid[h_addr] <= 1'b1;
        if (h_pos == '0) frame_time <= h_now;
      end
      if (cmd.tail_emit && cmd.tail_par) par_valid[cnt] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_data || cmd.tail_emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_data) begin
      m_tuser <= PKT_DATA;
      m_tlast <= status.in_range && status.is_last;
      m_tdata <= {6'd0, h_word, h_pos, base, count, h_now, h_seq};
    end else if (cmd.tail_emit) begin
      m_tuser <= cmd.tail_par ? PKT_PARITY : PKT_DATA;
      m_tlast <= status.cnt_last;
      m_tdata <= {6'd0, (cmd.tail_par ? par_word : rd_frm), POS_W'(cnt), base, count,
                  (cmd.tail_par ? h_now : frame_time), h_seq};
    end
  end

endmodule

### design/xor_parity_fec_packetizer_core.sv
// ----------------------------------------------------------------------------
// xor_parity_fec_packetizer_core
// XOR parity FEC packetizer: passes payload words on as data packet words,
// accumulates per-position parity, replays early frames of a group and
// emits the parity packet when a group closes.
//
// Channel  Dir  Handshake          Contents
// s        in   s_tvalid/tready    one payload word with its frame header
// m        out  m_tvalid/tready    one packet word; tuser kind, tlast end
// cfg      in   cfg_we             register write, index and data
//
// Each input word goes through the registered read of the parity store,
// then the parity update and the load of the output register. A frame's
// last word that triggers a replay or parity packet then walks each packet
// word through the same registered store read and an output register load.
// rst is synchronous; it clears control state, the parity valid bits,
// frame_time and the config registers to their defaults, with no sweep.
// m_tready low with m_tvalid high holds the output register and emit states.
// ----------------------------------------------------------------------------
module xor_parity_fec_packetizer_core
  import xfec_pkg::*;
#(
  parameter int WORDS_PER_FRAME = 20
)
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // frame_seq[31:0], now_ms[63:32], word_index[68:64], payload_word[132:69]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // out_seq[31:0], send_ms[63:32], group_count[68:64], grp_start[84:69],
  // out_word_index[89:85], out_word[153:90]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // packet_kind[0]
  output logic                   m_tuser,
  output logic                   m_tlast
);

  cmd_t    cmd;
  status_t status;

  xfec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  xfec_datapath #(
    .WORDS_PER_FRAME (WORDS_PER_FRAME)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
